// File: sv/bwpm_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and register codes for the blinds wipe pixel mask
// no dependencies; design files use scoped names, the testbench imports it
package bwpm_pkg;

    // pixel format
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int CHANNELS   = 4;
    localparam int NUM_CHAN   = 4;
    localparam int CHAN_W     = 8;

    // configuration widths
    localparam int AXIS_W     = 16;
    localparam int AXIS_FRAC  = 14;
    localparam int DIST_W     = 20;
    localparam int INV_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;

    // projection and blind coordinate
    localparam int PROD_W     = COORD_BITS + AXIS_W;
    localparam int PROJ_W     = PROD_W + 1;
    localparam int SHIFT      = AXIS_FRAC - FRAC_BITS;
    localparam int COARSE_W   = PROJ_W - SHIFT;
    localparam int MAG_W      = COARSE_W;
    localparam int DIV_STAGES = (MAG_W + 1) / 2;
    localparam int DIV_BITS   = 2 * DIV_STAGES;

    // visibility and channel scaling
    localparam int VIS_FRAC   = 24;
    localparam int VIS_W      = VIS_FRAC + 1;
    localparam int RAMP_W     = DIST_W + INV_W;
    localparam int CPROD_W    = CHAN_W + VIS_W;
    localparam int SCALED_W   = CPROD_W + 1 - VIS_FRAC;

    // stream widths
    localparam int CHAN_ALL_W = NUM_CHAN * CHAN_W;
    localparam int S_TDATA_W  = ((2 * COORD_BITS + CHAN_ALL_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((CHAN_ALL_W + 7) / 8) * 8;

    // pipeline sizing
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int FRONT_STAGES = 3;
    localparam int POST_STAGES  = 5;
    localparam int PIPE_CAP     = FRONT_STAGES + FIFO_DEPTH + DIV_STAGES + POST_STAGES;
    localparam int PEND_W       = $clog2(PIPE_CAP + 1) + 1;

    localparam logic [DIST_W-1:0]    PERIOD_MIN = DIST_W'(1 << FRAC_BITS);
    localparam logic [VIS_W-1:0]     VIS_ONE    = VIS_W'(1) << VIS_FRAC;
    localparam logic [CPROD_W:0]     VIS_HALF   = (CPROD_W + 1)'(1) << (VIS_FRAC - 1);
    localparam logic [CHAN_W-1:0]    CHAN_MAX   = CHAN_W'(255);

    // reset values of the registers
    localparam logic [AXIS_W-1:0] RST_AXIS_COS   = AXIS_W'(16384);
    localparam logic [AXIS_W-1:0] RST_AXIS_SIN   = AXIS_W'(0);
    localparam logic [DIST_W-1:0] RST_PERIOD     = DIST_W'(10240);
    localparam logic [DIST_W-1:0] RST_OPEN       = DIST_W'(10240);
    localparam logic [DIST_W-1:0] RST_FEATHER    = DIST_W'(0);
    localparam logic [INV_W-1:0]  RST_FEATHER_INV = INV_W'(0);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_AXIS_COS    = 3'd0,
        REG_AXIS_SIN    = 3'd1,
        REG_PERIOD      = 3'd2,
        REG_OPEN        = 3'd3,
        REG_FEATHER     = 3'd4,
        REG_FEATHER_INV = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        VIS_ZERO,
        VIS_FULL,
        VIS_RAMP
    } vis_sel_t;

    typedef struct packed {
        logic [AXIS_W-1:0] axis_cos;
        logic [AXIS_W-1:0] axis_sin;
        logic [DIST_W-1:0] blind_period;
        logic [DIST_W-1:0] open_width;
        logic [DIST_W-1:0] feather_width;
        logic [INV_W-1:0]  feather_inverse;
    } cfg_t;

    // classified pixel: sign and magnitude of the coarse projection
    typedef struct packed {
        logic                  neg;
        logic [MAG_W-1:0]      mag;
        logic [CHAN_ALL_W-1:0] chan;
    } item_t;

endpackage

// File: sv/bwpm_fifo.sv
`timescale 1ns / 1ps
// short register queue between the front and back parts of the wipe mask
// depends on bwpm_pkg for the item type and depth
module bwpm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bwpm_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output bwpm_pkg::item_t head
);

    bwpm_pkg::item_t                        mem_reg [bwpm_pkg::FIFO_DEPTH];
    logic [bwpm_pkg::FIFO_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bwpm_pkg::FIFO_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bwpm_pkg::FIFO_CNT_W-1:0]        count_reg, count_next;

    localparam logic [bwpm_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        bwpm_pkg::FIFO_PTR_W'(bwpm_pkg::FIFO_DEPTH - 1);
    localparam logic [bwpm_pkg::FIFO_CNT_W-1:0] CNT_FULL =
        bwpm_pkg::FIFO_CNT_W'(bwpm_pkg::FIFO_DEPTH);

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/bwpm_front.sv
`timescale 1ns / 1ps
// front part: accepts pixels, projects them onto the blind axis and splits
// the coarse coordinate into sign and magnitude; depends on bwpm_pkg
module bwpm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bwpm_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bwpm_pkg::S_TDATA_W-1:0]   in_data,
    input  logic                             fifo_full,
    output logic                             push,
    output bwpm_pkg::item_t                  push_item
);

    localparam int CB = bwpm_pkg::COORD_BITS;

    logic signed [CB-1:0]                     pixel_x, pixel_y;
    logic signed [bwpm_pkg::PROD_W-1:0]       prod_x_next, prod_y_next;
    logic signed [bwpm_pkg::PROD_W-1:0]       prod_x_reg, prod_y_reg;
    logic signed [bwpm_pkg::PROJ_W-1:0]       sum_next;
    logic [bwpm_pkg::COARSE_W-1:0]            coarse_next, coarse_reg;
    logic [bwpm_pkg::CHAN_ALL_W-1:0]          chan1_reg, chan2_reg;
    logic                                     valid1_reg, valid2_reg, valid3_reg;
    logic                                     front_en;
    bwpm_pkg::item_t                          item_next, item_reg;

    // the front stages stall only when stage 3 holds an item the queue cannot take
    assign front_en  = !(valid3_reg && fifo_full);
    assign in_ready  = aresetn && front_en;
    assign push      = valid3_reg && !fifo_full;
    assign push_item = item_reg;

    assign pixel_x = $signed(in_data[CB-1:0]);
    assign pixel_y = $signed(in_data[2*CB-1:CB]);

    assign prod_x_next = bwpm_pkg::PROD_W'(pixel_x)
                       * bwpm_pkg::PROD_W'($signed(cfg.axis_cos));
    assign prod_y_next = bwpm_pkg::PROD_W'(pixel_y)
                       * bwpm_pkg::PROD_W'($signed(cfg.axis_sin));

    // taking the upper bits of the signed sum rounds toward minus infinity
    assign sum_next    = $signed({prod_x_reg[bwpm_pkg::PROD_W-1], prod_x_reg})
                       + $signed({prod_y_reg[bwpm_pkg::PROD_W-1], prod_y_reg});
    assign coarse_next = sum_next[bwpm_pkg::PROJ_W-1:bwpm_pkg::SHIFT];

    always_comb begin
        item_next.neg  = coarse_reg[bwpm_pkg::COARSE_W-1];
        item_next.mag  = item_next.neg ? (~coarse_reg + 1'b1) : coarse_reg;
        item_next.chan = chan2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else if (front_en) begin
            valid1_reg <= in_valid && in_ready;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (front_en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            chan1_reg  <= in_data[2*CB +: bwpm_pkg::CHAN_ALL_W];
            coarse_reg <= coarse_next;
            chan2_reg  <= chan1_reg;
            item_reg   <= item_next;
        end
    end

endmodule

// File: sv/bwpm_back.sv
`timescale 1ns / 1ps
// back part: pipelined positive modulo by the blind period, visibility ramp
// and channel scaling with the output register; depends on bwpm_pkg
module bwpm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bwpm_pkg::cfg_t                  cfg,
    input  logic                            fifo_empty,
    input  bwpm_pkg::item_t                 fifo_head,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bwpm_pkg::M_TDATA_W-1:0]  m_data
);

    localparam int DS = bwpm_pkg::DIV_STAGES;
    localparam int DW = bwpm_pkg::DIST_W;
    localparam int CW = bwpm_pkg::CHAN_W;
    localparam int NC = bwpm_pkg::NUM_CHAN;

    logic                             back_en;
    logic [DW-1:0]                    period;

    logic                             div_valid_reg [DS];
    logic [DW-1:0]                    div_rem_reg   [DS];
    logic [bwpm_pkg::DIV_BITS-1:0]    div_quo_reg   [DS];
    logic                             div_neg_reg   [DS];
    logic [bwpm_pkg::CHAN_ALL_W-1:0]  div_chan_reg  [DS];

    logic                             a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [DW-1:0]                    a_coord_reg, a_coord_next;
    logic [bwpm_pkg::CHAN_ALL_W-1:0]  a_chan_reg, b_chan_reg, c_chan_reg;
    bwpm_pkg::vis_sel_t               b_sel_reg, b_sel_next, c_sel_reg;
    logic [DW-1:0]                    b_diff_reg, b_diff_next;
    logic [DW-1:0]                    feather_lim, ramp_edge;
    logic [bwpm_pkg::RAMP_W-1:0]      c_ramp_reg;
    logic [bwpm_pkg::VIS_W-1:0]       vis;
    logic [bwpm_pkg::CPROD_W-1:0]     cprod_next [NC];
    logic [bwpm_pkg::CPROD_W-1:0]     cprod_reg  [NC];
    logic [bwpm_pkg::CPROD_W:0]       rounded    [NC];
    logic [bwpm_pkg::SCALED_W-1:0]    scaled     [NC];
    logic [bwpm_pkg::M_TDATA_W-1:0]   m_data_next;
    logic [bwpm_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic                             m_valid_reg;

    // one restoring remainder step; rem < per on entry and on exit
    function automatic logic [DW-1:0] mod_step(input logic [DW-1:0] rem, input logic b,
                                               input logic [DW-1:0] per);
        logic [DW:0] t;
        t = {rem, b};
        if (t >= {1'b0, per}) begin
            t = t - {1'b0, per};
        end
        return t[DW-1:0];
    endfunction

    // the whole back pipeline moves unless the output register is held
    assign back_en = !m_valid_reg || m_ready;
    assign pop     = back_en && !fifo_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign period = (cfg.blind_period < bwpm_pkg::PERIOD_MIN) ?
                    bwpm_pkg::PERIOD_MIN : cfg.blind_period;

    // remainder pipeline, two dividend bits per stage
    for (genvar i = 0; i < DS; i++) begin : g_div
        logic                             valid_in;
        logic [DW-1:0]                    rem_in, rem_mid, rem_out;
        logic [bwpm_pkg::DIV_BITS-1:0]    quo_in;
        logic                             neg_in;
        logic [bwpm_pkg::CHAN_ALL_W-1:0]  chan_in;

        if (i == 0) begin : g_first
            assign valid_in = !fifo_empty;
            assign rem_in   = '0;
            assign quo_in   = bwpm_pkg::DIV_BITS'(fifo_head.mag);
            assign neg_in   = fifo_head.neg;
            assign chan_in  = fifo_head.chan;
        end else begin : g_next
            assign valid_in = div_valid_reg[i-1];
            assign rem_in   = div_rem_reg[i-1];
            assign quo_in   = div_quo_reg[i-1];
            assign neg_in   = div_neg_reg[i-1];
            assign chan_in  = div_chan_reg[i-1];
        end

        assign rem_mid = mod_step(rem_in, quo_in[bwpm_pkg::DIV_BITS-1], period);
        assign rem_out = mod_step(rem_mid, quo_in[bwpm_pkg::DIV_BITS-2], period);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[i] <= 1'b0;
            end else if (back_en) begin
                div_valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (back_en) begin
                div_rem_reg[i]  <= rem_out;
                div_quo_reg[i]  <= {quo_in[bwpm_pkg::DIV_BITS-3:0], 2'b00};
                div_neg_reg[i]  <= neg_in;
                div_chan_reg[i] <= chan_in;
            end
        end
    end

    // negative projections fold back into the period
    assign a_coord_next = (div_neg_reg[DS-1] && div_rem_reg[DS-1] != '0) ?
                          period - div_rem_reg[DS-1] : div_rem_reg[DS-1];

    assign feather_lim = (cfg.feather_width > cfg.open_width) ?
                         cfg.open_width : cfg.feather_width;
    assign ramp_edge   = cfg.open_width - feather_lim;
    assign b_diff_next = cfg.open_width - a_coord_reg;

    always_comb begin
        if (a_coord_reg < ramp_edge || feather_lim == '0) begin
            b_sel_next = (a_coord_reg < cfg.open_width) ? bwpm_pkg::VIS_FULL
                                                        : bwpm_pkg::VIS_ZERO;
        end else if (a_coord_reg < cfg.open_width) begin
            b_sel_next = bwpm_pkg::VIS_RAMP;
        end else begin
            b_sel_next = bwpm_pkg::VIS_ZERO;
        end
    end

    always_comb begin
        case (c_sel_reg)
            bwpm_pkg::VIS_FULL: vis = bwpm_pkg::VIS_ONE;
            bwpm_pkg::VIS_RAMP: begin
                vis = (c_ramp_reg > bwpm_pkg::RAMP_W'(bwpm_pkg::VIS_ONE)) ?
                      bwpm_pkg::VIS_ONE : c_ramp_reg[bwpm_pkg::VIS_W-1:0];
            end
            default:            vis = '0;
        endcase
    end

    always_comb begin
        m_data_next = '0;
        for (int k = 0; k < NC; k++) begin
            cprod_next[k] = bwpm_pkg::CPROD_W'(c_chan_reg[k*CW +: CW])
                          * bwpm_pkg::CPROD_W'(vis);
            rounded[k]    = {1'b0, cprod_reg[k]} + bwpm_pkg::VIS_HALF;
            scaled[k]     = rounded[k][bwpm_pkg::CPROD_W:bwpm_pkg::VIS_FRAC];
            if (k < bwpm_pkg::CHANNELS) begin
                m_data_next[k*CW +: CW] =
                    (scaled[k] > bwpm_pkg::SCALED_W'(bwpm_pkg::CHAN_MAX)) ?
                    bwpm_pkg::CHAN_MAX : scaled[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            b_sel_reg   <= bwpm_pkg::VIS_ZERO;
            c_sel_reg   <= bwpm_pkg::VIS_ZERO;
        end else if (back_en) begin
            a_valid_reg <= div_valid_reg[DS-1];
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            m_valid_reg <= d_valid_reg;
            b_sel_reg   <= b_sel_next;
            c_sel_reg   <= b_sel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            a_coord_reg <= a_coord_next;
            a_chan_reg  <= div_chan_reg[DS-1];
            b_diff_reg  <= b_diff_next;
            b_chan_reg  <= a_chan_reg;
            c_ramp_reg  <= bwpm_pkg::RAMP_W'(b_diff_reg)
                         * bwpm_pkg::RAMP_W'(cfg.feather_inverse);
            c_chan_reg  <= b_chan_reg;
            cprod_reg   <= cprod_next;
            m_data_reg  <= m_data_next;
        end
    end

endmodule

// File: sv/blinds_wipe_pixel_mask.sv
`timescale 1ns / 1ps
// venetian blinds wipe mask: takes one pixel and its four channel bytes a cycle
// and returns the channels scaled by the blind visibility at that position.
// s_ side: s_tdata carries the pixel, m_ side: m_tdata carries the result.
// cfg_we/cfg_addr/cfg_wdata write the axis, period, widths and feather inverse;
// write them only while no pixel is in flight.
// throughput: one pixel per clock, sustained while m_tready stays high.
// path from the accepting edge to m_tvalid: three front stages, one queue slot,
// a 14-stage remainder pipeline that takes two dividend bits a stage, and five
// stages of ramp, scaling and output.
// the front and back halves stall separately: a low m_tready while m_tvalid is
// high freezes the back pipeline and holds m_tdata; the four-entry queue keeps
// absorbing front results, and s_tready falls only once that queue is full.
// reset (aresetn low, synchronous) empties every stage, drops s_tready for its
// duration and loads the registers with their power-on values.
module blinds_wipe_pixel_mask (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_x, pixel_y, chan0_in, chan1_in, chan2_in, chan3_in
    input  logic [bwpm_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // chan0_out, chan1_out, chan2_out, chan3_out
    output logic [bwpm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [bwpm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bwpm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    bwpm_pkg::cfg_t   cfg_reg;
    bwpm_pkg::item_t  push_item, fifo_head;
    logic             push, pop, fifo_full, fifo_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_cos        <= bwpm_pkg::RST_AXIS_COS;
            cfg_reg.axis_sin        <= bwpm_pkg::RST_AXIS_SIN;
            cfg_reg.blind_period    <= bwpm_pkg::RST_PERIOD;
            cfg_reg.open_width      <= bwpm_pkg::RST_OPEN;
            cfg_reg.feather_width   <= bwpm_pkg::RST_FEATHER;
            cfg_reg.feather_inverse <= bwpm_pkg::RST_FEATHER_INV;
        end else if (cfg_we) begin
            case (cfg_addr)
                bwpm_pkg::REG_AXIS_COS:    cfg_reg.axis_cos <= cfg_wdata[bwpm_pkg::AXIS_W-1:0];
                bwpm_pkg::REG_AXIS_SIN:    cfg_reg.axis_sin <= cfg_wdata[bwpm_pkg::AXIS_W-1:0];
                bwpm_pkg::REG_PERIOD:      cfg_reg.blind_period <= cfg_wdata[bwpm_pkg::DIST_W-1:0];
                bwpm_pkg::REG_OPEN:        cfg_reg.open_width <= cfg_wdata[bwpm_pkg::DIST_W-1:0];
                bwpm_pkg::REG_FEATHER:     cfg_reg.feather_width <= cfg_wdata[bwpm_pkg::DIST_W-1:0];
                bwpm_pkg::REG_FEATHER_INV: cfg_reg.feather_inverse <= cfg_wdata[bwpm_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    bwpm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    bwpm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head      (fifo_head)
    );

    bwpm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_head  (fifo_head),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata)
    );

endmodule

// File: sv/bwpm_checker.sv
`timescale 1ns / 1ps
// port-level checks for blinds_wipe_pixel_mask, attached by the bind below
// depends on bwpm_pkg for the pipeline capacity
module bwpm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bwpm_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [bwpm_pkg::PEND_W-1:0] pend_reg, pend_next;

    // requests taken in but not yet delivered
    always_comb begin
        pend_next = pend_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            pend_next = pend_reg + 1'b1;
        end else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready)) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != '0)
        else $error("result shown with no request outstanding");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= bwpm_pkg::PEND_W'(bwpm_pkg::PIPE_CAP))
        else $error("more requests in flight than the pipeline holds");

endmodule

bind blinds_wipe_pixel_mask bwpm_checker u_bwpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the blinds wipe pixel mask: directed edge cases, then
// randomised register settings with raster and scattered pixels, random stalls both sides
// depends on bwpm_pkg and blinds_wipe_pixel_mask
module tb_top;
    import bwpm_pkg::*;

    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT  = 4000;
    localparam int IDLE_PCT     = 32;

    // expected-result store and bit-exact copy of the mask arithmetic
    class blind_mask_scoreboard;
        logic [AXIS_W-1:0]     axis_cos;
        logic [AXIS_W-1:0]     axis_sin;
        logic [DIST_W-1:0]     period;
        logic [DIST_W-1:0]     open_w;
        logic [DIST_W-1:0]     feather;
        logic [INV_W-1:0]      feather_inv;
        logic [M_TDATA_W-1:0]  masked_q[$];
        int unsigned           taken;
        int unsigned           checked;
        int unsigned           errors;
        int unsigned           vis_count[3];

        function new();
            axis_cos    = 16'd16384;
            axis_sin    = 16'd0;
            period      = 20'd10240;
            open_w      = 20'd10240;
            feather     = 20'd0;
            feather_inv = 24'd0;
            taken       = 0;
            checked     = 0;
            errors      = 0;
            vis_count   = '{0, 0, 0};
        endfunction

        function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
            case (r)
                REG_AXIS_COS:    axis_cos    = v[AXIS_W-1:0];
                REG_AXIS_SIN:    axis_sin    = v[AXIS_W-1:0];
                REG_PERIOD:      period      = v[DIST_W-1:0];
                REG_OPEN:        open_w      = v[DIST_W-1:0];
                REG_FEATHER:     feather     = v[DIST_W-1:0];
                REG_FEATHER_INV: feather_inv = v[INV_W-1:0];
                default: ;
            endcase
        endfunction

        // project, wrap into the blind, derive visibility and scale the channels
        function void take_pixel(logic [S_TDATA_W-1:0] d);
            longint            px;
            longint            py;
            longint            proj;
            longint            coarse;
            longint            span;
            longint            rem;
            longint unsigned   coord;
            longint unsigned   open_u;
            longint unsigned   fw;
            longint unsigned   vis;
            longint unsigned   chan;
            longint unsigned   scaled;
            vis_sel_t          kind;
            logic [M_TDATA_W-1:0] res;
            px     = longint'($signed(d[COORD_BITS-1:0]));
            py     = longint'($signed(d[2*COORD_BITS-1:COORD_BITS]));
            proj   = px * longint'($signed(axis_cos)) + py * longint'($signed(axis_sin));
            coarse = proj >>> (AXIS_FRAC - FRAC_BITS);
            span   = longint'(period);
            // under one pixel the period is taken as one pixel
            if (span < (longint'(1) << FRAC_BITS)) span = longint'(1) << FRAC_BITS;
            rem = coarse % span;
            if (rem < 0) rem = rem + span;
            coord  = rem;
            open_u = 64'(open_w);
            fw     = 64'(feather);
            if (fw > open_u) fw = open_u;
            if (coord < open_u - fw || fw == 0) begin
                if (coord < open_u) begin
                    vis  = 64'd1 << VIS_FRAC;
                    kind = VIS_FULL;
                end else begin
                    vis  = 0;
                    kind = VIS_ZERO;
                end
            end else if (coord < open_u) begin
                vis  = (open_u - coord) * 64'(feather_inv);
                kind = VIS_RAMP;
                if (vis > (64'd1 << VIS_FRAC)) vis = 64'd1 << VIS_FRAC;
            end else begin
                vis  = 0;
                kind = VIS_ZERO;
            end
            res = '0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                chan   = 64'(d[2*COORD_BITS + CHAN_W*i +: CHAN_W]);
                scaled = (chan * vis + (64'd1 << (VIS_FRAC - 1))) >> VIS_FRAC;
                if (scaled > 64'd255) scaled = 64'd255;
                if (i < CHANNELS) res[CHAN_W*i +: CHAN_W] = scaled[CHAN_W-1:0];
            end
            vis_count[int'(kind)]++;
            taken++;
            masked_q.push_back(res);
        endfunction

        function void check_pixel(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (masked_q.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with no pixel outstanding", $time, got);
                return;
            end
            want = masked_q.pop_front();
            checked++;
            for (int i = 0; i < NUM_CHAN; i++) begin
                if (want[CHAN_W*i +: CHAN_W] !== got[CHAN_W*i +: CHAN_W]) begin
                    errors++;
                    $display("%0t: pixel %0d chan%0d_out expected %0d actual %0d",
                             $time, checked, i, want[CHAN_W*i +: CHAN_W],
                             got[CHAN_W*i +: CHAN_W]);
                end
            end
        endfunction

        function int pending();
            return masked_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // pixel_x, pixel_y, chan0_in, chan1_in, chan2_in, chan3_in
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // chan0_out, chan1_out, chan2_out, chan3_out
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    blind_mask_scoreboard   sb = new();
    bit                     no_idle = 1'b0;
    int                     stall_cycles = 0;
    int                     settings_done = 0;

    blinds_wipe_pixel_mask u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, checked on the accepting edge
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
            $display("FAIL blinds_wipe_pixel_mask");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pixel_word(int x, int y, logic [7:0] c0,
                                                        logic [7:0] c1, logic [7:0] c2,
                                                        logic [7:0] c3);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[COORD_BITS-1:0]              = COORD_BITS'(x);
        w[2*COORD_BITS-1:COORD_BITS]   = COORD_BITS'(y);
        w[2*COORD_BITS +: CHAN_ALL_W]  = {c3, c2, c1, c0};
        return w;
    endfunction

    // present one pixel request, with random gaps in front of it
    task automatic send_pixel(logic [S_TDATA_W-1:0] word);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sb.take_pixel(word);
    endtask

    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, int v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= CFG_DATA_W'(v);
        sb.write_reg(r, CFG_DATA_W'(v));
    endtask

    task automatic program_blind(int cosv, int sinv, int per, int opn, int fw, int inv);
        write_reg(REG_AXIS_COS, cosv);
        write_reg(REG_AXIS_SIN, sinv);
        write_reg(REG_PERIOD, per);
        write_reg(REG_OPEN, opn);
        write_reg(REG_FEATHER, fw);
        write_reg(REG_FEATHER_INV, inv);
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    function automatic int inverse_of(int fw);
        if (fw == 0) return 0;
        if (fw == 1) return 24'hFFFFFF;
        return (1 << 24) / fw;
    endfunction

    task automatic pick_setting(int style);
        int cosv;
        int sinv;
        int per;
        int opn;
        int fw;
        int inv;
        cosv = int'($urandom_range(0, 32768)) - 16384;
        sinv = int'($urandom_range(0, 32768)) - 16384;
        case (style)
            0: begin
                per = $urandom_range(256, 8192);
                opn = $urandom_range(0, per + per / 4);
                fw  = $urandom_range(0, opn);
                inv = inverse_of(fw);
            end
            1: begin
                // over-wide feather and an inverse that does not match it
                per = $urandom_range(256, 8192);
                opn = $urandom_range(0, per);
                fw  = $urandom_range(0, 2 * opn + 1);
                inv = $urandom_range(0, 24'hFFFFFF);
            end
            2: begin
                cosv = $urandom;
                sinv = $urandom;
                per  = $urandom;
                opn  = $urandom;
                fw   = $urandom;
                inv  = $urandom;
            end
            3: begin
                per = $urandom_range(200000, 1048575);
                opn = $urandom_range(per - 60000, 1048575);
                fw  = $urandom_range(0, 300000);
                inv = inverse_of(fw > opn ? opn : fw);
            end
            default: begin
                // short period, hard or tiny feather, axis-aligned or diagonal blinds
                per  = $urandom_range(0, 300);
                opn  = $urandom_range(0, 320);
                fw   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
                inv  = inverse_of(fw);
                cosv = $urandom_range(0, 1) ? 16384 : -16384;
                sinv = $urandom_range(0, 1) ? 0 : cosv;
            end
        endcase
        program_blind(cosv, sinv, per, opn, fw, inv);
    endtask

    initial begin
        int rx;
        int ry;
        int x;
        int y;
        logic [7:0] c [4];

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // power-on setting: open covers the whole period
        send_pixel(pixel_word(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel_word(-32768, -32768, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pixel_word(32767, 32767, 8'hFF, 8'h00, 8'hFF, 8'h00));
        send_pixel(pixel_word(-1, 1, 8'h80, 8'h7F, 8'h01, 8'hFE));
        drain_pipeline();

        // hard edge at open width, negative x wraps positively
        program_blind(16384, 0, 2560, 1280, 0, 0);
        send_pixel(pixel_word(4, 0, 8'hFF, 8'hAA, 8'h55, 8'h01));
        send_pixel(pixel_word(5, 0, 8'hFF, 8'hAA, 8'h55, 8'h01));
        send_pixel(pixel_word(-1, 0, 8'hFF, 8'hAA, 8'h55, 8'h01));
        send_pixel(pixel_word(-6, 0, 8'hFF, 8'hAA, 8'h55, 8'h01));
        drain_pipeline();

        // linear ramp from open minus feather down to open
        program_blind(16384, 0, 2560, 2048, 1024, 16384);
        send_pixel(pixel_word(4, 0, 8'hFF, 8'hFF, 8'h80, 8'h01));
        send_pixel(pixel_word(5, 0, 8'hFF, 8'hFF, 8'h80, 8'h01));
        send_pixel(pixel_word(7, 0, 8'hFF, 8'hFF, 8'h80, 8'h01));
        send_pixel(pixel_word(8, 0, 8'hFF, 8'hFF, 8'h80, 8'h01));
        drain_pipeline();

        // short period, feather wider than open, saturating inverse
        program_blind(1000, -3, 100, 200, 300, 24'hFFFFFF);
        send_pixel(pixel_word(1, 0, 8'hFF, 8'h10, 8'h20, 8'h30));
        send_pixel(pixel_word(0, 1, 8'hFF, 8'h10, 8'h20, 8'h30));
        send_pixel(pixel_word(3, 7, 8'hFF, 8'h10, 8'h20, 8'h30));
        send_pixel(pixel_word(-5, 2, 8'hFF, 8'h10, 8'h20, 8'h30));
        drain_pipeline();

        // axis patterns beyond one, open equal to the widest period
        program_blind(24'hFF8000, 24'h007FFF, 1048575, 1048575, 5, 1);
        send_pixel(pixel_word(-32768, 32767, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel_word(32767, -32768, 8'h01, 8'h02, 8'h03, 8'h04));
        send_pixel(pixel_word(123, -456, 8'h80, 8'h80, 8'h80, 8'h80));
        drain_pipeline();

        // nothing open
        program_blind(16384, 16384, 256, 0, 0, 0);
        send_pixel(pixel_word(7, -9, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(pixel_word(-32768, 0, 8'hFF, 8'h00, 8'hFF, 8'h00));
        drain_pipeline();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick_setting(ph % 5);
            no_idle = (ph == 4 || ph == 5);
            rx = int'($urandom_range(0, 65535)) - 32768;
            ry = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly a raster walk, the rest scattered over the full range
                if ($urandom_range(0, 99) < 60) begin
                    x = rx + (k % 32);
                    y = ry + (k / 32);
                end else begin
                    x = $urandom;
                    y = $urandom;
                end
                for (int i = 0; i < 4; i++)
                    c[i] = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
                send_pixel(pixel_word(x, y, c[0], c[1], c[2], c[3]));
            end
            drain_pipeline();
        end
        no_idle = 1'b0;

        $display("covered %0d pixels over %0d register settings, %0d results checked",
                 sb.taken, settings_done + 1, sb.checked);
        $display("visibility seen: full %0d, ramp %0d, zero %0d; %0d mismatches",
                 sb.vis_count[int'(VIS_FULL)], sb.vis_count[int'(VIS_RAMP)],
                 sb.vis_count[int'(VIS_ZERO)], sb.errors);
        if (sb.errors == 0) begin
            $display("PASS blinds_wipe_pixel_mask");
        end else begin
            $display("FAIL blinds_wipe_pixel_mask");
        end
        $finish;
    end

endmodule
